>>> design/mlpsb_pkg.sv
// Package for the sigmoid perceptron classifier: sizes, state and operation codes,
// shared types, the sigmoid table and the fixed-point helper functions. No dependencies.
`default_nettype none
package mlpsb_pkg;

  localparam int IN_N      = 3;
  localparam int HID_N     = 3;
  localparam int OUT_N     = 4;
  localparam int FRAC_BITS = 12;
  localparam int IH_COUNT  = (IN_N + 1) * HID_N;
  localparam int W_COUNT   = IH_COUNT + (HID_N + 1) * OUT_N;
  localparam int ACC_W     = 34;
  localparam int DOUT_W    = 25;
  localparam int DHID_W    = 30;
  localparam int ESQ_W     = 27;

  localparam int STEP_MAX_A = (IN_N > HID_N) ? IN_N : HID_N;
  localparam int STEP_MAX   = (STEP_MAX_A > OUT_N - 1) ? STEP_MAX_A : OUT_N - 1;
  localparam int STEP_W     = $clog2(STEP_MAX + 1);

  localparam logic signed [15:0] ONE_W = 16'sd4096;
  localparam logic [12:0]        ONE_A = 13'd4096;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_INFER = 2'd1;
  localparam logic [1:0] OP_TRAIN = 2'd2;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_HMAC = 4'd1;
  localparam logic [3:0] ST_HSIG = 4'd2;
  localparam logic [3:0] ST_OMAC = 4'd3;
  localparam logic [3:0] ST_OSIG = 4'd4;
  localparam logic [3:0] ST_ODA  = 4'd5;
  localparam logic [3:0] ST_ODB  = 4'd6;
  localparam logic [3:0] ST_HSUM = 4'd7;
  localparam logic [3:0] ST_HDA  = 4'd8;
  localparam logic [3:0] ST_HDB  = 4'd9;
  localparam logic [3:0] ST_LRM  = 4'd10;
  localparam logic [3:0] ST_UPD  = 4'd11;
  localparam logic [3:0] ST_DONE = 4'd12;

  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

  typedef struct packed {
    logic [3:0]        state;
    logic [STEP_W-1:0] step;
  } ctl_t;

  typedef logic [12:0] sig_rom_t [256];

  function automatic sig_rom_t build_rom();
    logic [63:0] epow [129];
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] q;
    logic [63:0] s;
    int          m;
    int          am;
    sig_rom_t    rom;
    epow[0] = 64'd1 << 32;
    for (int k = 1; k <= 128; k++) begin
      epow[k] = (epow[k-1] * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    for (int k = 0; k < 256; k++) begin
      m   = k - 128;
      am  = (m < 0) ? -m : m;
      d   = (64'd1 << 32) + epow[am];
      num = (64'd1 << (FRAC_BITS + 32)) + (d >> 1);
      rem = '0;
      q   = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= d) begin
          rem  = rem - d;
          q[b] = 1'b1;
        end
      end
      s = q;
      if (m < 0) begin
        s = (64'd1 << FRAC_BITS) - q;
      end
      rom[k] = s[12:0];
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_rom();

  function automatic logic [7:0] sig_index(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] lim;
    logic signed [ACC_W-1:0] t;
    lim = ACC_W'(64'sd8 <<< (2 * FRAC_BITS));
    t   = acc + lim;
    if (acc < -lim) begin
      return 8'd0;
    end else if (acc >= lim) begin
      return 8'd255;
    end
    return t[2*FRAC_BITS+3 -: 8];
  endfunction

  function automatic logic signed [15:0] sat_w(input logic signed [24:0] v);
    if (v > 25'sd32767) begin
      return 16'sh7fff;
    end else if (v < -25'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage
`default_nettype wire

>>> design/mlpsb_hid_lane.sv
// One hidden neuron lane: its input weights, forward sum, sigmoid, hidden delta
// and weight update. Depends on mlpsb_pkg.
`default_nettype none
module mlpsb_hid_lane (
  input  logic                                  clk_i,
  input  mlpsb_pkg::ctl_t                       ctl_i,
  input  logic signed [15:0]                    x_i [mlpsb_pkg::IN_N],
  input  logic signed [mlpsb_pkg::DOUT_W-1:0]   dout_i [mlpsb_pkg::OUT_N],
  input  logic signed [15:0]                    wcol_i [mlpsb_pkg::OUT_N],
  input  logic [12:0]                           lr_i,
  input  logic [mlpsb_pkg::IN_N:0]              load_en_i,
  input  logic signed [15:0]                    load_value_i,
  output logic [12:0]                           h_o
);

  logic signed [15:0]                  w_q [mlpsb_pkg::IN_N+1];
  logic signed [mlpsb_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic [12:0]                         h_q;
  logic signed [42:0]                  s_q, s_d;
  logic signed [30:0]                  sr_q;
  logic [22:0]                         hp_q;
  logic signed [mlpsb_pkg::DHID_W-1:0] dhid_q;
  logic signed [43:0]                  lrd_q;

  logic signed [15:0] xo, wo, dw;
  logic signed [mlpsb_pkg::DOUT_W-1:0] dsel;
  logic signed [31:0] mac;
  logic signed [40:0] sterm;
  logic signed [54:0] dprod;
  logic signed [59:0] uprod;
  logic signed [59:0] urnd;
  logic signed [24:0] usum;
  logic signed [15:0] wnew;

  always_comb begin
    xo   = mlpsb_pkg::ONE_W;
    dsel = '0;
    dw   = '0;
    for (int i = 0; i < mlpsb_pkg::IN_N; i++) begin
      if (ctl_i.step == mlpsb_pkg::STEP_W'(i)) begin
        xo = x_i[i];
      end
    end
    for (int k = 0; k < mlpsb_pkg::OUT_N; k++) begin
      if (ctl_i.step == mlpsb_pkg::STEP_W'(k)) begin
        dsel = dout_i[k];
        dw   = wcol_i[k];
      end
    end
    wo    = w_q[ctl_i.step];
    mac   = xo * wo;
    acc_d = ((ctl_i.step == '0) ? '0 : acc_q) + mlpsb_pkg::ACC_W'(mac);
    sterm = dsel * dw;
    s_d   = ((ctl_i.step == '0) ? '0 : s_q) + 43'(sterm);
    dprod = sr_q * $signed({1'b0, hp_q});
    uprod = lrd_q * xo;
    urnd  = (uprod + (60'sd1 <<< 35)) >>> 36;
    usum  = 25'(wo) + urnd[24:0];
    wnew  = mlpsb_pkg::sat_w(usum);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i <= mlpsb_pkg::IN_N; i++) begin
      if (load_en_i[i]) begin
        w_q[i] <= load_value_i;
      end else if (ctl_i.state == mlpsb_pkg::ST_UPD && ctl_i.step == mlpsb_pkg::STEP_W'(i)) begin
        w_q[i] <= wnew;
      end
    end
    unique case (ctl_i.state)
      mlpsb_pkg::ST_HMAC: acc_q <= acc_d;
      mlpsb_pkg::ST_HSIG: h_q <= mlpsb_pkg::SIG_ROM[mlpsb_pkg::sig_index(acc_q)];
      mlpsb_pkg::ST_HSUM: s_q <= s_d;
      mlpsb_pkg::ST_HDA: begin
        sr_q <= 31'(s_q >>> mlpsb_pkg::FRAC_BITS);
        hp_q <= 23'(h_q) * (23'(mlpsb_pkg::ONE_A) - 23'(h_q));
      end
      mlpsb_pkg::ST_HDB: dhid_q <= mlpsb_pkg::DHID_W'(dprod >>> (2 * mlpsb_pkg::FRAC_BITS));
      mlpsb_pkg::ST_LRM: lrd_q <= $signed({1'b0, lr_i}) * dhid_q;
      default: ;
    endcase
  end

  assign h_o = h_q;

endmodule
`default_nettype wire

>>> design/mlpsb_out_lane.sv
// One output neuron lane: its hidden weights, forward sum, sigmoid, error, output
// delta and weight update. Depends on mlpsb_pkg.
`default_nettype none
module mlpsb_out_lane (
  input  logic                                clk_i,
  input  mlpsb_pkg::ctl_t                     ctl_i,
  input  logic [12:0]                         h_i [mlpsb_pkg::HID_N],
  input  logic [12:0]                         target_i,
  input  logic [12:0]                         lr_i,
  input  logic [mlpsb_pkg::HID_N:0]           load_en_i,
  input  logic signed [15:0]                  load_value_i,
  output logic signed [15:0]                  w_o [mlpsb_pkg::HID_N+1],
  output logic [12:0]                         a_o,
  output logic [mlpsb_pkg::ESQ_W-1:0]         esq_o,
  output logic signed [mlpsb_pkg::DOUT_W-1:0] dout_o
);

  logic signed [15:0]                  w_q [mlpsb_pkg::HID_N+1];
  logic signed [mlpsb_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic [12:0]                         a_q;
  logic signed [13:0]                  e_q;
  logic [22:0]                         p_q;
  logic signed [mlpsb_pkg::DOUT_W-1:0] dout_q;
  logic [mlpsb_pkg::ESQ_W-1:0]         esq_q;
  logic signed [38:0]                  lrd_q;

  logic signed [15:0] ho, wo;
  logic signed [31:0] mac;
  logic signed [14:0] ediff;
  logic signed [36:0] ep;
  logic signed [27:0] esq;
  logic signed [54:0] uprod;
  logic signed [54:0] urnd;
  logic signed [24:0] usum;
  logic signed [15:0] wnew;

  always_comb begin
    ho = mlpsb_pkg::ONE_W;
    for (int j = 0; j < mlpsb_pkg::HID_N; j++) begin
      if (ctl_i.step == mlpsb_pkg::STEP_W'(j)) begin
        ho = $signed({3'b000, h_i[j]});
      end
    end
    wo    = w_q[ctl_i.step];
    mac   = ho * wo;
    acc_d = ((ctl_i.step == '0) ? '0 : acc_q) + mlpsb_pkg::ACC_W'(mac);
    ediff = $signed({2'b00, target_i}) - $signed({2'b00, a_q});
    ep    = e_q * $signed({1'b0, p_q});
    esq   = e_q * e_q;
    uprod = lrd_q * ho;
    urnd  = (uprod + (55'sd1 <<< 35)) >>> 36;
    usum  = 25'(wo) + urnd[24:0];
    wnew  = mlpsb_pkg::sat_w(usum);
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= mlpsb_pkg::HID_N; j++) begin
      if (load_en_i[j]) begin
        w_q[j] <= load_value_i;
      end else if (ctl_i.state == mlpsb_pkg::ST_UPD && ctl_i.step == mlpsb_pkg::STEP_W'(j)) begin
        w_q[j] <= wnew;
      end
    end
    unique case (ctl_i.state)
      mlpsb_pkg::ST_OMAC: acc_q <= acc_d;
      mlpsb_pkg::ST_OSIG: a_q <= mlpsb_pkg::SIG_ROM[mlpsb_pkg::sig_index(acc_q)];
      mlpsb_pkg::ST_ODA: begin
        e_q <= ediff[13:0];
        p_q <= 23'(a_q) * (23'(mlpsb_pkg::ONE_A) - 23'(a_q));
      end
      mlpsb_pkg::ST_ODB: begin
        dout_q <= mlpsb_pkg::DOUT_W'(ep >>> mlpsb_pkg::FRAC_BITS);
        esq_q  <= esq[mlpsb_pkg::ESQ_W-1:0];
      end
      mlpsb_pkg::ST_LRM: lrd_q <= $signed({1'b0, lr_i}) * dout_q;
      default: ;
    endcase
  end

  assign w_o    = w_q;
  assign a_o    = a_q;
  assign esq_o  = esq_q;
  assign dout_o = dout_q;

endmodule
`default_nettype wire

>>> design/mlpsb_merge.sv
// Merging stage: picks the action from the output activations and totals the
// squared error of the output lanes. Depends on mlpsb_pkg.
`default_nettype none
module mlpsb_merge (
  input  logic                        clk_i,
  input  mlpsb_pkg::ctl_t             ctl_i,
  input  logic [12:0]                 a_i [mlpsb_pkg::OUT_N],
  input  logic [mlpsb_pkg::ESQ_W-1:0] esq_i [mlpsb_pkg::OUT_N],
  output logic [1:0]                  action_o,
  output logic [13:0]                 hse_o
);

  logic [1:0]  action_q, best;
  logic [13:0] hse_q;
  logic [29:0] sq;
  logic [16:0] half;

  always_comb begin
    best = '0;
    sq   = '0;
    for (int i = 1; i < mlpsb_pkg::OUT_N; i++) begin
      if (a_i[i] > a_i[best]) begin
        best = 2'(i);
      end
    end
    for (int i = 0; i < mlpsb_pkg::OUT_N; i++) begin
      sq = sq + 30'(esq_i[i]);
    end
    half = 17'(sq >> (mlpsb_pkg::FRAC_BITS + 1));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.state == mlpsb_pkg::ST_ODA) begin
      action_q <= best;
    end
    if (ctl_i.state == mlpsb_pkg::ST_HSUM) begin
      hse_q <= (half > 17'd16383) ? 14'd16383 : half[13:0];
    end
  end

  assign action_o = action_q;
  assign hse_o    = hse_q;

endmodule
`default_nettype wire

>>> design/mlp_sigmoid_backprop_classifier_unit.sv
// Load and unused requests go straight to completion; infer runs the forward pass and
// train also the backward pass and weight update; one request is worked on at a time.
// The sequencer steps each lane over its weights.
// Reset clears the sequencer, output valid and the learning-rate register (0.2); weights
// are undefined until loaded. Depends on mlpsb_pkg and the lane and merge modules.
`default_nettype none
module mlp_sigmoid_backprop_classifier_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [4:0]         weight_index_i,
  input  logic signed [15:0] weight_value_i,
  input  logic signed [15:0] feature_a_i,
  input  logic signed [15:0] feature_b_i,
  input  logic signed [15:0] feature_c_i,
  input  logic [12:0]        target_a_i,
  input  logic [12:0]        target_b_i,
  input  logic [12:0]        target_c_i,
  input  logic [12:0]        target_d_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         action_o,
  output logic [12:0]        activation_a_o,
  output logic [12:0]        activation_b_o,
  output logic [12:0]        activation_c_o,
  output logic [12:0]        activation_d_o,
  output logic [13:0]        half_square_error_o
);

  localparam int SW = mlpsb_pkg::STEP_W;

  logic [3:0]  state_q, state_d;
  logic [SW-1:0] step_q, step_d;
  logic [12:0] lr_q;
  logic [1:0]  op_q;
  logic        accept, finish;
  logic        out_valid_q;
  logic [1:0]  action_q;
  logic [12:0] act_q [mlpsb_pkg::OUT_N];
  logic [13:0] hse_q;
  mlpsb_pkg::ctl_t ctl;

  logic signed [15:0] x_q [mlpsb_pkg::IN_N];
  logic [12:0]        t_q [mlpsb_pkg::OUT_N];
  logic [12:0]        h   [mlpsb_pkg::HID_N];
  logic [12:0]        a   [mlpsb_pkg::OUT_N];
  logic [mlpsb_pkg::ESQ_W-1:0]         esq  [mlpsb_pkg::OUT_N];
  logic signed [mlpsb_pkg::DOUT_W-1:0] dout [mlpsb_pkg::OUT_N];
  logic signed [15:0] ow   [mlpsb_pkg::OUT_N][mlpsb_pkg::HID_N+1];
  logic signed [15:0] wcol [mlpsb_pkg::HID_N][mlpsb_pkg::OUT_N];
  logic [mlpsb_pkg::IN_N:0]  hid_load [mlpsb_pkg::HID_N];
  logic [mlpsb_pkg::HID_N:0] out_load [mlpsb_pkg::OUT_N];
  logic [1:0]  m_action;
  logic [13:0] m_hse;
  logic        is_load;

  assign pready     = 1'b1;
  assign prdata     = (paddr == 3'd0) ? {19'd0, lr_q} : 32'd0;
  assign in_stall_o = (state_q != mlpsb_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign finish     = (state_q == mlpsb_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);
  assign is_load    = accept && (operation_i == mlpsb_pkg::OP_LOAD);
  assign ctl        = '{state: state_q, step: step_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= 13'd819;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      lr_q <= pwdata[12:0];
    end
  end

  always_comb begin
    for (int j = 0; j < mlpsb_pkg::HID_N; j++) begin
      for (int i = 0; i <= mlpsb_pkg::IN_N; i++) begin
        hid_load[j][i] = is_load && (weight_index_i == 5'(i * mlpsb_pkg::HID_N + j));
      end
    end
    for (int k = 0; k < mlpsb_pkg::OUT_N; k++) begin
      for (int j = 0; j <= mlpsb_pkg::HID_N; j++) begin
        out_load[k][j] = is_load &&
          (weight_index_i == 5'(mlpsb_pkg::IH_COUNT + j * mlpsb_pkg::OUT_N + k));
      end
      for (int j = 0; j < mlpsb_pkg::HID_N; j++) begin
        wcol[j][k] = ow[k][j];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q + SW'(1);
    unique case (state_q)
      mlpsb_pkg::ST_IDLE: begin
        step_d = '0;
        if (accept) begin
          if (operation_i == mlpsb_pkg::OP_INFER || operation_i == mlpsb_pkg::OP_TRAIN) begin
            state_d = mlpsb_pkg::ST_HMAC;
          end else begin
            state_d = mlpsb_pkg::ST_DONE;
          end
        end
      end
      mlpsb_pkg::ST_HMAC: begin
        if (step_q == SW'(mlpsb_pkg::IN_N)) begin
          state_d = mlpsb_pkg::ST_HSIG;
          step_d  = '0;
        end
      end
      mlpsb_pkg::ST_HSIG: begin
        state_d = mlpsb_pkg::ST_OMAC;
        step_d  = '0;
      end
      mlpsb_pkg::ST_OMAC: begin
        if (step_q == SW'(mlpsb_pkg::HID_N)) begin
          state_d = mlpsb_pkg::ST_OSIG;
          step_d  = '0;
        end
      end
      mlpsb_pkg::ST_OSIG: begin
        state_d = mlpsb_pkg::ST_ODA;
        step_d  = '0;
      end
      mlpsb_pkg::ST_ODA: begin
        state_d = (op_q == mlpsb_pkg::OP_TRAIN) ? mlpsb_pkg::ST_ODB : mlpsb_pkg::ST_DONE;
        step_d  = '0;
      end
      mlpsb_pkg::ST_ODB: begin
        state_d = mlpsb_pkg::ST_HSUM;
        step_d  = '0;
      end
      mlpsb_pkg::ST_HSUM: begin
        if (step_q == SW'(mlpsb_pkg::OUT_N - 1)) begin
          state_d = mlpsb_pkg::ST_HDA;
          step_d  = '0;
        end
      end
      mlpsb_pkg::ST_HDA: begin
        state_d = mlpsb_pkg::ST_HDB;
        step_d  = '0;
      end
      mlpsb_pkg::ST_HDB: begin
        state_d = mlpsb_pkg::ST_LRM;
        step_d  = '0;
      end
      mlpsb_pkg::ST_LRM: begin
        state_d = mlpsb_pkg::ST_UPD;
        step_d  = '0;
      end
      mlpsb_pkg::ST_UPD: begin
        if (step_q == SW'(mlpsb_pkg::STEP_MAX_A)) begin
          state_d = mlpsb_pkg::ST_DONE;
          step_d  = '0;
        end
      end
      mlpsb_pkg::ST_DONE: begin
        step_d = '0;
        if (finish) begin
          state_d = mlpsb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mlpsb_pkg::ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlpsb_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      x_q[0] <= feature_a_i;
      x_q[1] <= feature_b_i;
      x_q[2] <= feature_c_i;
      t_q[0] <= target_a_i;
      t_q[1] <= target_b_i;
      t_q[2] <= target_c_i;
      t_q[3] <= target_d_i;
    end
    if (finish) begin
      if (op_q == mlpsb_pkg::OP_INFER || op_q == mlpsb_pkg::OP_TRAIN) begin
        action_q <= m_action;
        act_q    <= a;
        hse_q    <= (op_q == mlpsb_pkg::OP_TRAIN) ? m_hse : 14'd0;
      end else begin
        action_q <= '0;
        hse_q    <= '0;
        for (int k = 0; k < mlpsb_pkg::OUT_N; k++) begin
          act_q[k] <= '0;
        end
      end
    end
  end

  for (genvar j = 0; j < mlpsb_pkg::HID_N; j++) begin : g_hid
    mlpsb_hid_lane u_hid (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .x_i          (x_q),
      .dout_i       (dout),
      .wcol_i       (wcol[j]),
      .lr_i         (lr_q),
      .load_en_i    (hid_load[j]),
      .load_value_i (weight_value_i),
      .h_o          (h[j])
    );
  end

  for (genvar k = 0; k < mlpsb_pkg::OUT_N; k++) begin : g_out
    mlpsb_out_lane u_out (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .h_i          (h),
      .target_i     (t_q[k]),
      .lr_i         (lr_q),
      .load_en_i    (out_load[k]),
      .load_value_i (weight_value_i),
      .w_o          (ow[k]),
      .a_o          (a[k]),
      .esq_o        (esq[k]),
      .dout_o       (dout[k])
    );
  end

  mlpsb_merge u_merge (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .a_i      (a),
    .esq_i    (esq),
    .action_o (m_action),
    .hse_o    (m_hse)
  );

  assign out_valid_o         = out_valid_q;
  assign action_o            = action_q;
  assign activation_a_o      = act_q[0];
  assign activation_b_o      = act_q[1];
  assign activation_c_o      = act_q[2];
  assign activation_d_o      = act_q[3];
  assign half_square_error_o = hse_q;

`ifndef SYNTHESIS
  a_infer_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && operation_i == mlpsb_pkg::OP_INFER |=> state_q == mlpsb_pkg::ST_HMAC)
    else $error("infer request did not start the forward pass");
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && operation_i == mlpsb_pkg::OP_LOAD |=> state_q == mlpsb_pkg::ST_DONE)
    else $error("load request did not go straight to completion");
  a_act_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> activation_a_o <= 13'd4096 && activation_d_o <= 13'd4096)
    else $error("activation above one");
  a_upd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mlpsb_pkg::ST_UPD && step_q == SW'(mlpsb_pkg::STEP_MAX_A)
    |=> state_q == mlpsb_pkg::ST_DONE)
    else $error("update pass did not end");
  a_hse_train: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish && op_q != mlpsb_pkg::OP_TRAIN |=> half_square_error_o == 14'd0)
    else $error("error reported outside training");
`endif

endmodule
`default_nettype wire

>>> bench/tb_mlp_sigmoid_backprop_classifier_unit.sv
// Testbench for the sigmoid perceptron classifier: loads weights, runs infer and train
// requests against a fixed-point predictor of the network and checks every result.
// Depends on mlpsb_pkg and mlp_sigmoid_backprop_classifier_unit.
`default_nettype none
module tb_mlp_sigmoid_backprop_classifier_unit;

  typedef struct packed {
    logic [1:0]         op;
    logic [4:0]         widx;
    logic signed [15:0] wval;
    logic signed [15:0] fa;
    logic signed [15:0] fb;
    logic signed [15:0] fc;
    logic [12:0]        ta;
    logic [12:0]        tb;
    logic [12:0]        tc;
    logic [12:0]        td;
  } req_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [12:0] act_a;
    logic [12:0] act_b;
    logic [12:0] act_c;
    logic [12:0] act_d;
    logic [13:0] hse;
  } res_t;

  localparam logic [2:0] ADDR_LR = 3'd0;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t req = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  res_t got;

  longint weights [mlpsb_pkg::W_COUNT];
  logic written [mlpsb_pkg::W_COUNT];
  longint lrate;
  logic [12:0] sig_tab [256];
  res_t expected_q [$];
  int mismatches = 0;
  int cycles = 0;

  always #1 clk_i = ~clk_i;

  mlp_sigmoid_backprop_classifier_unit dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o,
    .operation_i(req.op), .weight_index_i(req.widx), .weight_value_i(req.wval),
    .feature_a_i(req.fa), .feature_b_i(req.fb), .feature_c_i(req.fc),
    .target_a_i(req.ta), .target_b_i(req.tb), .target_c_i(req.tc), .target_d_i(req.td),
    .out_valid_o, .out_stall_i,
    .action_o(got.action), .activation_a_o(got.act_a), .activation_b_o(got.act_b),
    .activation_c_o(got.act_c), .activation_d_o(got.act_d),
    .half_square_error_o(got.hse)
  );

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void make_sig_table();
    longint unsigned ep [129];
    longint unsigned d, s;
    int m, am;
    ep[0] = 64'd1 << 32;
    for (int k = 1; k <= 128; k++) ep[k] = (ep[k-1] * 64'd4034748382 + (64'd1 << 31)) >> 32;
    for (int k = 0; k < 256; k++) begin
      m = k - 128;
      am = m < 0 ? -m : m;
      d = (64'd1 << 32) + ep[am];
      s = ((64'd1 << 44) + (d >> 1)) / d;
      if (m < 0) s = 4096 - s;
      sig_tab[k] = s[12:0];
    end
  endfunction

  function automatic longint sigmoid(longint acc);
    longint lim;
    lim = longint'(8) << 24;
    if (acc < -lim) return sig_tab[0];
    if (acc >= lim) return sig_tab[255];
    return sig_tab[(acc + lim) >>> 20];
  endfunction

  function automatic res_t network_step(req_t r);
    res_t o;
    longint x [3], t [4], h [3], a [4], dout [4], dhid [3];
    longint acc, e, sq, s;
    int best, w;
    o = '0;
    if (r.op == mlpsb_pkg::OP_LOAD) begin
      if (r.widx < mlpsb_pkg::W_COUNT) begin
        weights[r.widx] = r.wval;
        written[r.widx] = 1'b1;
      end
      return o;
    end
    if (r.op == OP_UNUSED) return o;
    x[0] = r.fa; x[1] = r.fb; x[2] = r.fc;
    t[0] = r.ta; t[1] = r.tb; t[2] = r.tc; t[3] = r.td;
    for (int j = 0; j < 3; j++) begin
      acc = weights[9 + j] * 4096;
      for (int i = 0; i < 3; i++) acc += x[i] * weights[i * 3 + j];
      h[j] = sigmoid(acc);
    end
    for (int k = 0; k < 4; k++) begin
      acc = weights[24 + k] * 4096;
      for (int j = 0; j < 3; j++) acc += h[j] * weights[12 + j * 4 + k];
      a[k] = sigmoid(acc);
    end
    best = 0;
    for (int k = 1; k < 4; k++) if (a[k] > a[best]) best = k;
    o.action = best[1:0];
    o.act_a = 13'(a[0]); o.act_b = 13'(a[1]); o.act_c = 13'(a[2]); o.act_d = 13'(a[3]);
    if (r.op == mlpsb_pkg::OP_TRAIN) begin
      sq = 0;
      for (int k = 0; k < 4; k++) begin
        e = t[k] - a[k];
        sq += e * e;
        dout[k] = floor_shift(e * a[k] * (4096 - a[k]), 12);
      end
      for (int j = 0; j < 3; j++) begin
        s = 0;
        for (int k = 0; k < 4; k++) s += dout[k] * weights[12 + j * 4 + k];
        s = floor_shift(s, 12);
        dhid[j] = floor_shift(s * (h[j] * (4096 - h[j])), 24);
      end
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 3; j++) begin
          w = 12 + j * 4 + k;
          weights[w] = clamp16(weights[w] +
                               floor_shift(lrate * dout[k] * h[j] + (longint'(1) << 35), 36));
        end
        weights[24 + k] = clamp16(weights[24 + k] +
                                  floor_shift(lrate * dout[k] + (longint'(1) << 23), 24));
      end
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          w = i * 3 + j;
          weights[w] = clamp16(weights[w] +
                               floor_shift(lrate * dhid[j] * x[i] + (longint'(1) << 35), 36));
        end
        weights[9 + j] = clamp16(weights[9 + j] +
                                 floor_shift(lrate * dhid[j] + (longint'(1) << 23), 24));
      end
      sq = floor_shift(sq, 13);
      o.hse = sq > 16383 ? 14'd16383 : sq[13:0];
    end
    return o;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Checker and random output stall.
  int stall_left = 0;
  always @(posedge clk_i) begin
    res_t exp_r;
    int wait_n;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r !== got) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", exp_r, got);
        end
      end
      wait_n = $urandom_range(0, 7);
      stall_left <= wait_n;
      out_stall_i <= (wait_n != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      stall_left <= 0;
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_request(req_t r);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req <= r;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(network_step(r));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_lr(logic [12:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_LR; pwdata <= {19'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    lrate = v;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic req_t load_req(int idx, logic signed [15:0] v);
    req_t r;
    r = '0;
    r.op = mlpsb_pkg::OP_LOAD; r.widx = 5'(idx); r.wval = v;
    return r;
  endfunction

  function automatic req_t random_req(logic [1:0] op, bit wide);
    req_t r;
    r.op = op;
    r.widx = 5'($urandom_range(0, 31));
    r.wval = wide ? 16'($urandom) : 16'($urandom_range(0, 4096) - 2048);
    r.fa = wide ? 16'($urandom) : 16'($urandom_range(0, 16383) - 8192);
    r.fb = wide ? 16'($urandom) : 16'($urandom_range(0, 16383) - 8192);
    r.fc = wide ? 16'($urandom) : 16'($urandom_range(0, 16383) - 8192);
    r.ta = 13'(wide ? $urandom : $urandom_range(0, 4096));
    r.tb = 13'(wide ? $urandom : $urandom_range(0, 4096));
    r.tc = 13'(wide ? $urandom : $urandom_range(0, 4096));
    r.td = 13'(wide ? $urandom : $urandom_range(0, 4096));
    return r;
  endfunction

  task automatic test_load_all();
    for (int i = 0; i < mlpsb_pkg::W_COUNT; i++) send_request(load_req(i, 16'($urandom)));
  endtask

  task automatic test_directed();
    req_t r;
    send_request(load_req(28, 16'sh7fff));
    send_request(load_req(31, 16'sh8000));
    r = random_req(OP_UNUSED, 1'b1);
    send_request(r);
    r = '0; r.op = mlpsb_pkg::OP_INFER;
    send_request(r);
    r.fa = 16'sh7fff; r.fb = 16'sh7fff; r.fc = 16'sh7fff;
    send_request(r);
    r.fa = 16'sh8000; r.fb = 16'sh8000; r.fc = 16'sh8000;
    send_request(r);
    for (int i = 0; i < mlpsb_pkg::W_COUNT; i++) send_request(load_req(i, 16'sd0));
    r = '0; r.op = mlpsb_pkg::OP_INFER;
    send_request(r);
    r.op = mlpsb_pkg::OP_TRAIN;
    r.ta = 13'h1fff; r.tb = 13'h1fff; r.tc = 13'h1fff; r.td = 13'h1fff;
    send_request(r);
    r.ta = 13'd0; r.tb = 13'd4096; r.tc = 13'd0; r.td = 13'd4096;
    send_request(r);
  endtask

  task automatic test_random(int count, bit wide);
    logic [1:0] op;
    for (int n = 0; n < count; n++) begin
      op = $urandom_range(0, 9) < 2 ? 2'($urandom_range(0, 3)) : 2'($urandom_range(1, 2));
      send_request(random_req(op, wide));
    end
  endtask

  task automatic test_lr_values();
    logic [12:0] rates [4] = '{13'd4096, 13'd0, 13'h1fff, 13'd819};
    foreach (rates[i]) begin
      wait_idle();
      write_lr(rates[i]);
      test_load_all();
      test_random(150, i == 2);
    end
  endtask

  initial begin
    make_sig_table();
    lrate = 819;
    for (int i = 0; i < mlpsb_pkg::W_COUNT; i++) begin
      weights[i] = 0;
      written[i] = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_all();
    test_directed();
    test_random(200, 1'b0);
    test_lr_values();
    test_random(150, 1'b1);
    wait_idle();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
design/mlpsb_pkg.sv
design/mlpsb_hid_lane.sv
design/mlpsb_out_lane.sv
design/mlpsb_merge.sv
design/mlp_sigmoid_backprop_classifier_unit.sv
bench/tb_mlp_sigmoid_backprop_classifier_unit.sv
